// ===== rtl/sgr_pkg.sv =====
// Shared types and constants for the SGR style decoder.
// Used by sgr_step, sgr_rsp_stage and sgr_style_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

   // Part kinds delivered by the tokenizer.
   localparam logic [2:0] KIND_ESC   = 3'd0;
   localparam logic [2:0] KIND_FE    = 3'd1;
   localparam logic [2:0] KIND_PARAM = 3'd2;
   localparam logic [2:0] KIND_INTER = 3'd3;
   localparam logic [2:0] KIND_FINAL = 3'd4;

   // Character codes checked on the introducer and the final.
   localparam logic [15:0] CHAR_LBRACKET = 16'h005B;
   localparam logic [15:0] CHAR_M        = 16'h006D;

   // Default color index (-1).
   localparam logic [15:0] COLOR_DEFAULT = 16'hFFFF;

   // Attribute bits.
   localparam int ATTR_BOLD_BIT  = 0;
   localparam int ATTR_UNDER_BIT = 1;
   localparam int ATTR_REV_BIT   = 2;

   // SGR parameter codes.
   localparam logic [15:0] SGR_RESET      = 16'd0;
   localparam logic [15:0] SGR_BOLD       = 16'd1;
   localparam logic [15:0] SGR_UNDER      = 16'd4;
   localparam logic [15:0] SGR_REV        = 16'd7;
   localparam logic [15:0] SGR_BOLD_OFF   = 16'd22;
   localparam logic [15:0] SGR_UNDER_OFF  = 16'd24;
   localparam logic [15:0] SGR_REV_OFF    = 16'd27;
   localparam logic [15:0] SGR_FG_FIRST   = 16'd30;
   localparam logic [15:0] SGR_FG_LAST    = 16'd37;
   localparam logic [15:0] SGR_FG_EXT     = 16'd38;
   localparam logic [15:0] SGR_FG_DEFAULT = 16'd39;
   localparam logic [15:0] SGR_BG_FIRST   = 16'd40;
   localparam logic [15:0] SGR_BG_LAST    = 16'd47;
   localparam logic [15:0] SGR_BG_EXT     = 16'd48;
   localparam logic [15:0] SGR_BG_DEFAULT = 16'd49;
   localparam logic [15:0] SGR_EXT_INDEX  = 16'd5;

   // Extended color phases.
   localparam logic [2:0] EXT_NONE     = 3'd0;
   localparam logic [2:0] EXT_FG_MODE  = 3'd1;
   localparam logic [2:0] EXT_FG_INDEX = 3'd2;
   localparam logic [2:0] EXT_BG_MODE  = 3'd3;
   localparam logic [2:0] EXT_BG_INDEX = 3'd4;

   // Position of the current part inside its sequence.
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   // Decoder state carried from part to part.
   typedef struct packed {
      logic [15:0] cmt_fore;
      logic [15:0] cmt_back;
      logic [2:0]  cmt_attrs;
      logic [15:0] wrk_fore;
      logic [15:0] wrk_back;
      logic [2:0]  wrk_attrs;
      logic [1:0]  position;
      logic        seq_valid;
      logic [2:0]  ext_phase;
      logic        saw_param;
   } state_type;

   // One result transaction.
   typedef struct packed {
      logic [15:0] fore_color;
      logic [15:0] back_color;
      logic        bold_on;
      logic        underline_on;
      logic        reverse_on;
      logic        accepted;
      logic        is_default;
   } result_type;

   localparam state_type STATE_RESET = '{
      cmt_fore:  COLOR_DEFAULT,
      cmt_back:  COLOR_DEFAULT,
      cmt_attrs: 3'd0,
      wrk_fore:  COLOR_DEFAULT,
      wrk_back:  COLOR_DEFAULT,
      wrk_attrs: 3'd0,
      position:  POS_FIRST,
      seq_valid: 1'b1,
      ext_phase: EXT_NONE,
      saw_param: 1'b0
   };

endpackage

`default_nettype wire

// ===== rtl/sgr_step.sv =====
// Combinational update for one escape-sequence part: next decoder state and result.
// Depends on sgr_pkg for the state and result types and the SGR codes.
`timescale 1ns / 1ps
`default_nettype none

module sgr_step
   import sgr_pkg::*;
(
   input  state_type   cur_state,
   input  logic [2:0]  part_kind,
   input  logic [15:0] part_value,
   input  logic        last_part,
   output state_type   nxt_state,
   output result_type  result
);

   // Working style, validity and parameter decode for this part.
   always_comb begin
      logic [15:0] wfore;
      logic [15:0] wback;
      logic [2:0]  wattrs;
      logic [2:0]  ext;
      logic        svalid;
      logic        saw;
      logic        acc;
      logic [1:0]  pos_next;

      wfore  = cur_state.wrk_fore;
      wback  = cur_state.wrk_back;
      wattrs = cur_state.wrk_attrs;
      ext    = cur_state.ext_phase;
      svalid = cur_state.seq_valid;
      saw    = cur_state.saw_param;

      // The first part reloads the working copy and must be an escape.
      if (cur_state.position == POS_FIRST) begin
         wfore  = cur_state.cmt_fore;
         wback  = cur_state.cmt_back;
         wattrs = cur_state.cmt_attrs;
         if (part_kind != KIND_ESC) begin
            svalid = 1'b0;
         end
      end else if (cur_state.position == POS_SECOND) begin
         if (part_kind != KIND_FE || part_value != CHAR_LBRACKET) begin
            svalid = 1'b0;
         end
      end

      if (part_kind == KIND_INTER) begin
         svalid = 1'b0;
      end
      if (part_kind == KIND_FINAL && part_value != CHAR_M) begin
         svalid = 1'b0;
      end

      // Apply one numeric parameter to the working copy.
      if (part_kind == KIND_PARAM && svalid) begin
         saw = 1'b1;
         case (ext)
            EXT_FG_MODE: begin
               ext = (part_value == SGR_EXT_INDEX) ? EXT_FG_INDEX : EXT_NONE;
            end
            EXT_FG_INDEX: begin
               wfore = part_value;
               ext   = EXT_NONE;
            end
            EXT_BG_MODE: begin
               ext = (part_value == SGR_EXT_INDEX) ? EXT_BG_INDEX : EXT_NONE;
            end
            EXT_BG_INDEX: begin
               wback = part_value;
               ext   = EXT_NONE;
            end
            default: begin
               ext = EXT_NONE;
               if (part_value == SGR_RESET) begin
                  wfore  = COLOR_DEFAULT;
                  wback  = COLOR_DEFAULT;
                  wattrs = 3'd0;
               end else if (part_value == SGR_BOLD) begin
                  wattrs[ATTR_BOLD_BIT] = 1'b1;
               end else if (part_value == SGR_UNDER) begin
                  wattrs[ATTR_UNDER_BIT] = 1'b1;
               end else if (part_value == SGR_REV) begin
                  wattrs[ATTR_REV_BIT] = 1'b1;
               end else if (part_value == SGR_BOLD_OFF) begin
                  wattrs[ATTR_BOLD_BIT] = 1'b0;
               end else if (part_value == SGR_UNDER_OFF) begin
                  wattrs[ATTR_UNDER_BIT] = 1'b0;
               end else if (part_value == SGR_REV_OFF) begin
                  wattrs[ATTR_REV_BIT] = 1'b0;
               end else if (part_value >= SGR_FG_FIRST && part_value <= SGR_FG_LAST) begin
                  wfore = part_value - SGR_FG_FIRST;
               end else if (part_value == SGR_FG_EXT) begin
                  ext = EXT_FG_MODE;
               end else if (part_value == SGR_FG_DEFAULT) begin
                  wfore = COLOR_DEFAULT;
               end else if (part_value >= SGR_BG_FIRST && part_value <= SGR_BG_LAST) begin
                  wback = part_value - SGR_BG_FIRST;
               end else if (part_value == SGR_BG_EXT) begin
                  ext = EXT_BG_MODE;
               end else if (part_value == SGR_BG_DEFAULT) begin
                  wback = COLOR_DEFAULT;
               end
            end
         endcase
      end

      pos_next = (cur_state.position == POS_FIRST) ? POS_SECOND : POS_LATER;

      // Default: carry the sequence on.
      nxt_state           = cur_state;
      nxt_state.wrk_fore  = wfore;
      nxt_state.wrk_back  = wback;
      nxt_state.wrk_attrs = wattrs;
      nxt_state.position  = pos_next;
      nxt_state.seq_valid = svalid;
      nxt_state.ext_phase = ext;
      nxt_state.saw_param = saw;

      // A sequence that never reached its second part is never accepted.
      acc = svalid && (cur_state.position != POS_FIRST);

      // The last part commits a valid sequence and restarts decoding.
      if (last_part) begin
         if (acc) begin
            if (!saw) begin
               nxt_state.cmt_fore  = COLOR_DEFAULT;
               nxt_state.cmt_back  = COLOR_DEFAULT;
               nxt_state.cmt_attrs = 3'd0;
            end else begin
               nxt_state.cmt_fore  = wfore;
               nxt_state.cmt_back  = wback;
               nxt_state.cmt_attrs = wattrs;
            end
         end
         nxt_state.position  = POS_FIRST;
         nxt_state.seq_valid = 1'b1;
         nxt_state.ext_phase = EXT_NONE;
         nxt_state.saw_param = 1'b0;
      end

      // Report the committed style after this part.
      result.fore_color   = nxt_state.cmt_fore;
      result.back_color   = nxt_state.cmt_back;
      result.bold_on      = nxt_state.cmt_attrs[ATTR_BOLD_BIT];
      result.underline_on = nxt_state.cmt_attrs[ATTR_UNDER_BIT];
      result.reverse_on   = nxt_state.cmt_attrs[ATTR_REV_BIT];
      result.accepted     = acc;
      result.is_default   = (nxt_state.cmt_fore == COLOR_DEFAULT)
                            && (nxt_state.cmt_back == COLOR_DEFAULT)
                            && (nxt_state.cmt_attrs == 3'd0);
   end

endmodule

`default_nettype wire

// ===== rtl/sgr_rsp_stage.sv =====
// Result register of the SGR style decoder, holding one transaction for the rsp channel.
// Depends on sgr_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module sgr_rsp_stage
   import sgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       slot_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The slot takes a new transaction when empty or being drained this cycle.
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/sgr_style_decoder.sv =====
// Top level of the SGR style decoder: input register, style state and result register.
// Depends on sgr_pkg, sgr_step and sgr_rsp_stage.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_part_kind, req_part_value, req_last_part
//   rsp      out        rsp_valid / rsp_ready  rsp_fore_color .. rsp_is_default
//
// One part is taken per cycle unless a last part waits for a free result slot.
// The input register feeds the decode logic, which updates the style state and loads
// the result register in the same cycle. Only parts marked last produce a transaction.
// A stalled rsp channel holds back a last part and the parts behind it; other parts keep flowing.
// Reset is synchronous and restores the default style with no scan or clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sgr_style_decoder
   import sgr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_part_kind,
   input  logic [15:0]        req_part_value,
   input  logic               req_last_part,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_fore_color,
   output logic signed [15:0] rsp_back_color,
   output logic               rsp_bold_on,
   output logic               rsp_underline_on,
   output logic               rsp_reverse_on,
   output logic               rsp_accepted,
   output logic               rsp_is_default
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [2:0]  in_kind_ff;
   logic [15:0] in_value_ff;
   logic        in_last_ff;
   state_type   state_ff;
   state_type   state_in;
   result_type  step_result;
   result_type  rsp_data;
   logic        slot_free;
   logic        req_fire;
   logic        proc_fire;

   // A registered part is decoded when its result, if any, has a free slot.
   assign proc_fire = in_valid_ff && (!in_last_ff || slot_free);
   assign req_ready = !in_valid_ff || proc_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Input register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff  <= req_part_kind;
         in_value_ff <= req_part_value;
         in_last_ff  <= req_last_part;
      end
   end

   // Decode of one part.
   sgr_step u_step (
      .cur_state  (state_ff),
      .part_kind  (in_kind_ff),
      .part_value (in_value_ff),
      .last_part  (in_last_ff),
      .nxt_state  (state_in),
      .result     (step_result)
   );

   // Style and sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (proc_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   sgr_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (proc_fire && in_last_ff),
      .load_data (step_result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_fore_color   = $signed(rsp_data.fore_color);
   assign rsp_back_color   = $signed(rsp_data.back_color);
   assign rsp_bold_on      = rsp_data.bold_on;
   assign rsp_underline_on = rsp_data.underline_on;
   assign rsp_reverse_on   = rsp_data.reverse_on;
   assign rsp_accepted     = rsp_data.accepted;
   assign rsp_is_default   = rsp_data.is_default;

`ifndef SYNTHESIS
   // The part position never takes its unused code.
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.position != 2'd3)
      else $error("sequence position out of range");

   // The extended color phase stays within its five phases.
   a_ext_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.ext_phase <= EXT_BG_INDEX)
      else $error("extended color phase out of range");

   // A decoded last part restarts the sequence.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_last_ff |=>
         state_ff.position == POS_FIRST && state_ff.ext_phase == EXT_NONE
         && state_ff.seq_valid && !state_ff.saw_param)
      else $error("sequence did not restart after last part");

   // A last part waits while a result is still held.
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_valid && !rsp_ready |-> !proc_fire)
      else $error("last part decoded over a held result");

   // A default report means default colors and no attributes.
   a_default_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_default |->
         rsp_fore_color == -16'sd1 && rsp_back_color == -16'sd1
         && !rsp_bold_on && !rsp_underline_on && !rsp_reverse_on)
      else $error("default flag disagrees with reported style");
`endif

endmodule

`default_nettype wire
